/* rtl/vcrp_pkg.sv */
package vcrp_pkg;

  // command codes
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_VBL_SET = 3'd2;
  localparam logic [2:0] CMD_VBL_CLR = 3'd3;
  localparam logic [2:0] CMD_DMA     = 3'd4;

  // register selects
  localparam logic [2:0] SEL_CTRL     = 3'd0;
  localparam logic [2:0] SEL_MASK     = 3'd1;
  localparam logic [2:0] SEL_STATUS   = 3'd2;
  localparam logic [2:0] SEL_OAM_ADDR = 3'd3;
  localparam logic [2:0] SEL_OAM_DATA = 3'd4;
  localparam logic [2:0] SEL_SCROLL   = 3'd5;
  localparam logic [2:0] SEL_ADDR     = 3'd6;
  localparam logic [2:0] SEL_DATA     = 3'd7;

  localparam logic [15:0] PALETTE_BASE = 16'h3F00;
  localparam logic [15:0] STEP_ROW     = 16'd32;
  localparam logic [15:0] STEP_COL     = 16'd1;

  // where the read byte of an item comes from
  typedef enum logic [1:0] {
    SRC_FIXED = 2'd0,
    SRC_OAM   = 2'd1,
    SRC_BUF   = 2'd2,
    SRC_PAL   = 2'd3
  } src_t;

  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] value;
    logic       nmi;
  } resp_info_t;

endpackage

/* rtl/vcrp_ram.sv */
module vcrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/vcrp_clear.sv */
module vcrp_clear #(
  parameter int VRAM_ADDR_BITS = 14,
  parameter int OAM_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  output logic                      busy,
  output logic                      oam_busy,
  output logic [VRAM_ADDR_BITS-1:0] cnt
);

  localparam logic [VRAM_ADDR_BITS:0] OAM_END = (VRAM_ADDR_BITS + 1)'(OAM_DEPTH);

  // sweep every vram entry once after reset, oam rides along in the first part
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (&cnt) begin
        busy <= 1'b0;
      end
    end
  end

  assign oam_busy = busy && ({1'b0, cnt} < OAM_END);

endmodule

/* rtl/vcrp_regs.sv */
module vcrp_regs #(
  parameter int VRAM_ADDR_BITS = 14,
  parameter int OAM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [2:0]                   command,
  input  logic [2:0]                   reg_addr,
  input  logic [7:0]                   write_data,
  input  logic [7:0]                   dma_index,
  output vcrp_pkg::mem_req_t           vram_req,
  output logic [VRAM_ADDR_BITS-1:0]    vram_addr,
  output vcrp_pkg::mem_req_t           oam_req,
  output logic [$clog2(OAM_DEPTH)-1:0] oam_addr,
  output vcrp_pkg::resp_info_t         info
);

  localparam int OAM_AW = $clog2(OAM_DEPTH);

  logic        ctrl_nmi, ctrl_nmi_next;
  logic        ctrl_inc, ctrl_inc_next;
  logic        vblank, vblank_next;
  logic [7:0]  sprite_addr, sprite_addr_next;
  logic [15:0] v, v_next;
  logic [14:0] t, t_next;
  logic        toggle, toggle_next;
  logic [15:0] v_step;
  logic [7:0]  dma_sum;
  logic        palette;

  assign v_step    = ctrl_inc ? vcrp_pkg::STEP_ROW : vcrp_pkg::STEP_COL;
  assign dma_sum   = sprite_addr + dma_index;
  assign vram_addr = v[VRAM_ADDR_BITS-1:0];
  assign palette   = 16'(v[VRAM_ADDR_BITS-1:0]) >= vcrp_pkg::PALETTE_BASE;

  always_comb begin
    ctrl_nmi_next    = ctrl_nmi;
    ctrl_inc_next    = ctrl_inc;
    vblank_next      = vblank;
    sprite_addr_next = sprite_addr;
    v_next           = v;
    t_next           = t;
    toggle_next      = toggle;
    vram_req         = '{en: 1'b0, we: 1'b0, wdata: write_data};
    oam_req          = '{en: 1'b0, we: 1'b0, wdata: write_data};
    oam_addr         = sprite_addr[OAM_AW-1:0];
    info.src         = vcrp_pkg::SRC_FIXED;
    info.value       = 8'h00;
    if (accept) begin
      case (command)
        vcrp_pkg::CMD_READ: begin
          case (reg_addr)
            vcrp_pkg::SEL_STATUS: begin
              info.value  = {vblank, 7'b0};
              vblank_next = 1'b0;
              toggle_next = 1'b0;
            end
            vcrp_pkg::SEL_OAM_DATA: begin
              oam_req.en = 1'b1;
              info.src   = vcrp_pkg::SRC_OAM;
            end
            vcrp_pkg::SEL_DATA: begin
              vram_req.en = 1'b1;
              info.src    = palette ? vcrp_pkg::SRC_PAL : vcrp_pkg::SRC_BUF;
              v_next      = v + v_step;
            end
            default: ;
          endcase
        end
        vcrp_pkg::CMD_WRITE: begin
          case (reg_addr)
            vcrp_pkg::SEL_CTRL: begin
              ctrl_nmi_next = write_data[7];
              ctrl_inc_next = write_data[2];
              t_next[11:10] = write_data[1:0];
            end
            vcrp_pkg::SEL_OAM_ADDR: begin
              sprite_addr_next = write_data;
            end
            vcrp_pkg::SEL_OAM_DATA: begin
              oam_req.en       = 1'b1;
              oam_req.we       = 1'b1;
              sprite_addr_next = sprite_addr + 8'd1;
            end
            vcrp_pkg::SEL_SCROLL: begin
              if (!toggle) begin
                t_next[4:0] = write_data[7:3];
                toggle_next = 1'b1;
              end else begin
                t_next[14:12] = write_data[2:0];
                t_next[9:5]   = write_data[7:3];
                toggle_next   = 1'b0;
              end
            end
            vcrp_pkg::SEL_ADDR: begin
              if (!toggle) begin
                t_next[14:8] = {1'b0, write_data[5:0]};
                toggle_next  = 1'b1;
              end else begin
                t_next[7:0] = write_data;
                v_next      = {1'b0, t[14:8], write_data};
                toggle_next = 1'b0;
              end
            end
            vcrp_pkg::SEL_DATA: begin
              vram_req.en = 1'b1;
              vram_req.we = 1'b1;
              v_next      = v + v_step;
            end
            default: ;
          endcase
        end
        vcrp_pkg::CMD_VBL_SET: vblank_next = 1'b1;
        vcrp_pkg::CMD_VBL_CLR: vblank_next = 1'b0;
        vcrp_pkg::CMD_DMA: begin
          oam_req.en = 1'b1;
          oam_req.we = 1'b1;
          oam_addr   = dma_sum[OAM_AW-1:0];
        end
        default: ;
      endcase
    end
    info.nmi = ctrl_nmi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_nmi    <= 1'b0;
      ctrl_inc    <= 1'b0;
      vblank      <= 1'b0;
      sprite_addr <= '0;
      v           <= '0;
      t           <= '0;
      toggle      <= 1'b0;
    end else begin
      ctrl_nmi    <= ctrl_nmi_next;
      ctrl_inc    <= ctrl_inc_next;
      vblank      <= vblank_next;
      sprite_addr <= sprite_addr_next;
      v           <= v_next;
      t           <= t_next;
      toggle      <= toggle_next;
    end
  end

endmodule

/* rtl/vcrp_resp.sv */
module vcrp_resp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  vcrp_pkg::resp_info_t info,
  input  logic [7:0]           vram_rdata,
  input  logic [7:0]           oam_rdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           read_data,
  output logic                 nmi_enable,
  output logic                 hold
);

  logic                 b_valid;
  vcrp_pkg::resp_info_t b_info;
  logic                 b_move;
  logic [7:0]           read_buffer;
  logic [7:0]           b_data;

  assign b_move = b_valid && (!out_valid || !out_stall);
  assign hold   = b_valid && !b_move;

  always_comb begin
    case (b_info.src)
      vcrp_pkg::SRC_OAM: b_data = oam_rdata;
      vcrp_pkg::SRC_BUF: b_data = read_buffer;
      vcrp_pkg::SRC_PAL: b_data = vram_rdata;
      default:           b_data = b_info.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_info <= info;
    end
    if (b_move) begin
      read_data  <= b_data;
      nmi_enable <= b_info.nmi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
      read_buffer <= '0;
    end else begin
      b_valid <= accept || hold;
      if (b_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // vram data reads refill the buffer, palette ones too
      if (b_move && (b_info.src inside {vcrp_pkg::SRC_BUF, vcrp_pkg::SRC_PAL})) begin
        read_buffer <= vram_rdata;
      end
    end
  end

endmodule

/* rtl/video_unit_cpu_register_port_core.sv */
// cpu register port of the video unit
// input channel (in_valid / in_stall): one item per bus access or event:
//   command, reg_addr, write_data, dma_index
// output channel (out_valid / out_stall): one item per input item:
//   read_data and nmi_enable, in input order
// an item is taken on a clock edge with valid high and stall low
// from the input edge the item goes through the registered read of vram or
// oam into the response stage, then into the output register (out_valid)
// a new item can be taken every cycle while in_stall is low; registers
// and memory writes are committed at the input edge, the read buffer in
// the response stage; while the output is stalled the response stage
// holds one item and the output register another; in_stall rises once
// both are full; after rst the port runs a clearing pass over all
// 2**VRAM_ADDR_BITS vram entries (16384 by default), oam is cleared while
// the counter is below OAM_DEPTH; in_stall stays high for the whole pass
module video_unit_cpu_register_port_core #(
  parameter int VRAM_ADDR_BITS = 14,
  parameter int OAM_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [7:0] dma_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       nmi_enable
);

  localparam int OAM_AW = $clog2(OAM_DEPTH);

  logic                      clr_busy;
  logic                      clr_oam;
  logic [VRAM_ADDR_BITS-1:0] clr_cnt;
  logic                      hold;
  logic                      accept;
  vcrp_pkg::mem_req_t        vram_req;
  vcrp_pkg::mem_req_t        oam_req;
  logic [VRAM_ADDR_BITS-1:0] req_vram_addr;
  logic [OAM_AW-1:0]         req_oam_addr;
  vcrp_pkg::resp_info_t      info;
  logic [7:0]                vram_rdata;
  logic [7:0]                oam_rdata;

  assign in_stall = clr_busy || hold;
  assign accept   = in_valid && !in_stall;

  vcrp_clear #(
    .VRAM_ADDR_BITS(VRAM_ADDR_BITS),
    .OAM_DEPTH     (OAM_DEPTH)
  ) u_clear (
    .clk     (clk),
    .rst     (rst),
    .busy    (clr_busy),
    .oam_busy(clr_oam),
    .cnt     (clr_cnt)
  );

  vcrp_regs #(
    .VRAM_ADDR_BITS(VRAM_ADDR_BITS),
    .OAM_DEPTH     (OAM_DEPTH)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .reg_addr  (reg_addr),
    .write_data(write_data),
    .dma_index (dma_index),
    .vram_req  (vram_req),
    .vram_addr (req_vram_addr),
    .oam_req   (oam_req),
    .oam_addr  (req_oam_addr),
    .info      (info)
  );

  vcrp_ram #(
    .WIDTH(8),
    .DEPTH(2 ** VRAM_ADDR_BITS)
  ) u_vram (
    .clk  (clk),
    .en   (clr_busy || vram_req.en),
    .we   (clr_busy || vram_req.we),
    .addr (clr_busy ? clr_cnt : req_vram_addr),
    .wdata(clr_busy ? 8'h00 : vram_req.wdata),
    .rdata(vram_rdata)
  );

  vcrp_ram #(
    .WIDTH(8),
    .DEPTH(OAM_DEPTH)
  ) u_oam (
    .clk  (clk),
    .en   (clr_oam || oam_req.en),
    .we   (clr_oam || oam_req.we),
    .addr (clr_oam ? clr_cnt[OAM_AW-1:0] : req_oam_addr),
    .wdata(clr_oam ? 8'h00 : oam_req.wdata),
    .rdata(oam_rdata)
  );

  vcrp_resp u_resp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .info      (info),
    .vram_rdata(vram_rdata),
    .oam_rdata (oam_rdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .read_data (read_data),
    .nmi_enable(nmi_enable),
    .hold      (hold)
  );

endmodule

/* rtl/vcrp_checker.sv */
module vcrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       nmi_enable
);

  // port busy clearing memory right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("input taken during the clearing pass");

  // once running, the input only stalls when the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> (in_stall == (out_valid && out_stall)))
    else $error("input stall does not follow output backpressure");

  // without backpressure an accepted item passes the response stage to out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !(out_valid && out_stall) |=> ##1 out_valid)
    else $error("result missing two cycles after item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(nmi_enable))
    else $error("stalled output item changed");

endmodule

bind video_unit_cpu_register_port_core vcrp_checker u_vcrp_checker (.*);
